/* src/arf_pkg.sv */
package arf_pkg;

    typedef enum logic {
        FIT_PILLARBOX,
        FIT_LETTERBOX
    } fit_mode_t;

    typedef struct packed {
        fit_mode_t mode;
        logic      div_zero;
    } fit_ctl_t;

    localparam logic CFG_DST_WIDTH  = 1'b0;
    localparam logic CFG_DST_HEIGHT = 1'b1;

    localparam int DST_WIDTH_RESET  = 1920;
    localparam int DST_HEIGHT_RESET = 1080;

endpackage

/* src/arf_front.sv */
module arf_front import arf_pkg::*; #(
    parameter int DIM_BITS   = 13,
    parameter int RATIO_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                valid_i,
    output logic                                ready_o,
    input  logic [DIM_BITS-1:0]                 src_width_i,
    input  logic [DIM_BITS-1:0]                 src_height_i,
    input  logic [RATIO_BITS-1:0]               aspect_num_i,
    input  logic [RATIO_BITS-1:0]               aspect_den_i,
    input  logic [DIM_BITS-1:0]                 dst_width_i,
    input  logic [DIM_BITS-1:0]                 dst_height_i,
    output logic                                valid_o,
    input  logic                                ready_i,
    output logic [2*DIM_BITS+RATIO_BITS-1:0]    num_o,
    output logic [DIM_BITS+RATIO_BITS-1:0]      den_o,
    output fit_ctl_t                            ctl_o
);

    localparam int PROD_W = 2 * DIM_BITS;
    localparam int NUM_W  = 2 * DIM_BITS + RATIO_BITS;
    localparam int DEN_W  = DIM_BITS + RATIO_BITS;

    logic                  a_vld_reg;
    logic [PROD_W-1:0]     a_sw_dh_reg;
    logic [PROD_W-1:0]     a_dw_sh_reg;
    logic [DEN_W-1:0]      a_sw_ad_reg;
    logic [DEN_W-1:0]      a_sh_an_reg;
    logic [RATIO_BITS-1:0] a_an_reg;
    logic [RATIO_BITS-1:0] a_ad_reg;

    logic                  b_vld_reg;
    logic [NUM_W-1:0]      b_s_reg;
    logic [NUM_W-1:0]      b_d_reg;
    logic [DEN_W-1:0]      b_sw_ad_reg;
    logic [DEN_W-1:0]      b_sh_an_reg;

    logic                  c_vld_reg;
    logic [NUM_W-1:0]      c_num_reg;
    logic [DEN_W-1:0]      c_den_reg;
    fit_ctl_t              c_ctl_reg;

    logic                  a_rdy;
    logic                  b_rdy;
    logic                  c_rdy;
    logic                  letterbox;
    logic [DEN_W-1:0]      den_next;

    assign c_rdy   = !c_vld_reg || ready_i;
    assign b_rdy   = !b_vld_reg || c_rdy;
    assign a_rdy   = !a_vld_reg || b_rdy;
    assign ready_o = a_rdy;

    assign letterbox = b_s_reg > b_d_reg;
    assign den_next  = letterbox ? b_sw_ad_reg : b_sh_an_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_vld_reg <= valid_i;
            end
            if (b_rdy) begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_rdy) begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_sw_dh_reg <= PROD_W'(src_width_i) * PROD_W'(dst_height_i);
            a_dw_sh_reg <= PROD_W'(dst_width_i) * PROD_W'(src_height_i);
            a_sw_ad_reg <= DEN_W'(src_width_i) * DEN_W'(aspect_den_i);
            a_sh_an_reg <= DEN_W'(src_height_i) * DEN_W'(aspect_num_i);
            a_an_reg    <= aspect_num_i;
            a_ad_reg    <= aspect_den_i;
        end
        if (b_rdy) begin
            b_s_reg     <= NUM_W'(a_sw_dh_reg) * NUM_W'(a_ad_reg);
            b_d_reg     <= NUM_W'(a_dw_sh_reg) * NUM_W'(a_an_reg);
            b_sw_ad_reg <= a_sw_ad_reg;
            b_sh_an_reg <= a_sh_an_reg;
        end
        if (c_rdy) begin
            c_num_reg          <= letterbox ? b_d_reg : b_s_reg;
            c_den_reg          <= den_next;
            c_ctl_reg.mode     <= letterbox ? FIT_LETTERBOX : FIT_PILLARBOX;
            c_ctl_reg.div_zero <= den_next == '0;
        end
    end

    assign valid_o = c_vld_reg;
    assign num_o   = c_num_reg;
    assign den_o   = c_den_reg;
    assign ctl_o   = c_ctl_reg;

endmodule

/* src/arf_div_cell.sv */
module arf_div_cell import arf_pkg::*; #(
    parameter int DIM_BITS   = 13,
    parameter int RATIO_BITS = 10,
    parameter int SHIFT      = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             valid_i,
    output logic                             ready_o,
    input  logic [2*DIM_BITS+RATIO_BITS-1:0] rem_i,
    input  logic [DIM_BITS+RATIO_BITS-1:0]   den_i,
    input  logic [DIM_BITS-1:0]              quot_i,
    input  fit_ctl_t                         ctl_i,
    output logic                             valid_o,
    input  logic                             ready_i,
    output logic [2*DIM_BITS+RATIO_BITS-1:0] rem_o,
    output logic [DIM_BITS+RATIO_BITS-1:0]   den_o,
    output logic [DIM_BITS-1:0]              quot_o,
    output fit_ctl_t                         ctl_o
);

    localparam int NUM_W = 2 * DIM_BITS + RATIO_BITS;
    localparam int DEN_W = DIM_BITS + RATIO_BITS;

    logic                valid_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DIM_BITS-1:0] quot_reg;
    fit_ctl_t            ctl_reg;

    logic [NUM_W-1:0]    trial;
    logic                fits;
    logic [NUM_W-1:0]    rem_next;
    logic [DIM_BITS-1:0] quot_next;

    assign ready_o   = !valid_reg || ready_i;
    assign trial     = NUM_W'(den_i) << SHIFT;
    assign fits      = rem_i >= trial;
    assign rem_next  = fits ? rem_i - trial : rem_i;
    assign quot_next = {quot_i[DIM_BITS-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o) begin
            rem_reg  <= rem_next;
            den_reg  <= den_i;
            quot_reg <= quot_next;
            ctl_reg  <= ctl_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign den_o   = den_reg;
    assign quot_o  = quot_reg;
    assign ctl_o   = ctl_reg;

endmodule

/* src/arf_fin.sv */
module arf_fin import arf_pkg::*; #(
    parameter int DIM_BITS = 13
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                valid_i,
    output logic                ready_o,
    input  logic [DIM_BITS-1:0] quot_i,
    input  fit_ctl_t            ctl_i,
    input  logic [DIM_BITS-1:0] dst_width_i,
    input  logic [DIM_BITS-1:0] dst_height_i,
    output logic                valid_o,
    input  logic                ready_i,
    output logic [DIM_BITS-1:0] fit_x_o,
    output logic [DIM_BITS-1:0] fit_y_o,
    output logic [DIM_BITS-1:0] fit_width_o,
    output logic [DIM_BITS-1:0] fit_height_o
);

    logic                valid_reg;
    logic [DIM_BITS-1:0] fit_x_reg;
    logic [DIM_BITS-1:0] fit_y_reg;
    logic [DIM_BITS-1:0] fit_width_reg;
    logic [DIM_BITS-1:0] fit_height_reg;

    logic [DIM_BITS-1:0] quot;
    logic [DIM_BITS-1:0] x_raw;
    logic [DIM_BITS-1:0] y_raw;
    logic [DIM_BITS-1:0] w_raw;
    logic [DIM_BITS-1:0] h_raw;
    logic [DIM_BITS-1:0] even_mask;

    assign ready_o   = !valid_reg || ready_i;
    assign quot      = ctl_i.div_zero ? '0 : quot_i;
    assign even_mask = ~DIM_BITS'(1);

    always_comb begin
        x_raw = '0;
        y_raw = '0;
        w_raw = dst_width_i;
        h_raw = dst_height_i;
        unique case (ctl_i.mode)
            FIT_LETTERBOX: begin
                h_raw = (quot > dst_height_i) ? dst_height_i : quot;
                y_raw = (dst_height_i - h_raw) >> 1;
            end
            FIT_PILLARBOX: begin
                w_raw = (quot > dst_width_i) ? dst_width_i : quot;
                x_raw = (dst_width_i - w_raw) >> 1;
            end
            default: begin
                w_raw = dst_width_i;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o) begin
            fit_x_reg      <= x_raw & even_mask;
            fit_y_reg      <= y_raw;
            fit_width_reg  <= w_raw & even_mask;
            fit_height_reg <= h_raw;
        end
    end

    assign valid_o      = valid_reg;
    assign fit_x_o      = fit_x_reg;
    assign fit_y_o      = fit_y_reg;
    assign fit_width_o  = fit_width_reg;
    assign fit_height_o = fit_height_reg;

    // The fitted x offset and width must be even, and the fitted area must always lie inside the destination area.
    a_even_x_w: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (fit_x_reg[0] == 1'b0 && fit_width_reg[0] == 1'b0))
        else $error("fitted x offset or width is odd");

    a_inside_h: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, fit_x_reg} + {1'b0, fit_width_reg}) <= {1'b0, dst_width_i})
        else $error("fitted area exceeds destination width");

    a_inside_v: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, fit_y_reg} + {1'b0, fit_height_reg}) <= {1'b0, dst_height_i})
        else $error("fitted area exceeds destination height");

endmodule

/* src/aspect_ratio_fit_top.sv */
// Fits a source picture of src_width x src_height pixels with pixel aspect ratio
// aspect_num:aspect_den into the destination area held in the dst_width and
// dst_height registers, choosing letterbox or pillarbox and centring the picture.
// One result follows every input transfer, and a new transfer can be accepted
// in every cycle unless m_tready stalls the output. The cross products and the
// letterbox decision are registered in the front stages, followed by one divider
// cell per quotient bit and a final register for the offsets and the output. The
// destination registers must only be written while no transfer is in flight.
module aspect_ratio_fit_top import arf_pkg::*; #(
    parameter int DIM_BITS   = 13,
    parameter int RATIO_BITS = 10
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            cfg_wr_en,
    input  logic                                            cfg_addr,
    input  logic [DIM_BITS-1:0]                             cfg_wr_data,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // src_width, src_height, aspect_num, aspect_den, from the lowest bit up.
    input  logic [((2*DIM_BITS+2*RATIO_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // fit_x, fit_y, fit_width, fit_height, from the lowest bit up.
    output logic [((4*DIM_BITS+7)/8)*8-1:0]                 m_tdata
);

    localparam int NUM_W = 2 * DIM_BITS + RATIO_BITS;
    localparam int DEN_W = DIM_BITS + RATIO_BITS;
    localparam int OUT_W = ((4 * DIM_BITS + 7) / 8) * 8;

    logic [DIM_BITS-1:0] dst_width_reg;
    logic [DIM_BITS-1:0] dst_height_reg;

    logic                valid_c [0:DIM_BITS];
    logic                ready_c [0:DIM_BITS];
    logic [NUM_W-1:0]    rem_c   [0:DIM_BITS];
    logic [DEN_W-1:0]    den_c   [0:DIM_BITS];
    logic [DIM_BITS-1:0] quot_c  [0:DIM_BITS];
    fit_ctl_t            ctl_c   [0:DIM_BITS];

    logic [DIM_BITS-1:0] fit_x;
    logic [DIM_BITS-1:0] fit_y;
    logic [DIM_BITS-1:0] fit_width;
    logic [DIM_BITS-1:0] fit_height;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_width_reg  <= DIM_BITS'(DST_WIDTH_RESET);
            dst_height_reg <= DIM_BITS'(DST_HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_wr_data;
                CFG_DST_HEIGHT: dst_height_reg <= cfg_wr_data;
                default: begin
                    dst_width_reg <= dst_width_reg;
                end
            endcase
        end
    end

    arf_front #(
        .DIM_BITS   (DIM_BITS),
        .RATIO_BITS (RATIO_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .valid_i      (s_tvalid),
        .ready_o      (s_tready),
        .src_width_i  (s_tdata[DIM_BITS-1:0]),
        .src_height_i (s_tdata[2*DIM_BITS-1:DIM_BITS]),
        .aspect_num_i (s_tdata[2*DIM_BITS+RATIO_BITS-1:2*DIM_BITS]),
        .aspect_den_i (s_tdata[2*DIM_BITS+2*RATIO_BITS-1:2*DIM_BITS+RATIO_BITS]),
        .dst_width_i  (dst_width_reg),
        .dst_height_i (dst_height_reg),
        .valid_o      (valid_c[0]),
        .ready_i      (ready_c[0]),
        .num_o        (rem_c[0]),
        .den_o        (den_c[0]),
        .ctl_o        (ctl_c[0])
    );

    assign quot_c[0] = '0;

    for (genvar i = 0; i < DIM_BITS; i++) begin : g_cell
        arf_div_cell #(
            .DIM_BITS   (DIM_BITS),
            .RATIO_BITS (RATIO_BITS),
            .SHIFT      (DIM_BITS - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (valid_c[i]),
            .ready_o (ready_c[i]),
            .rem_i   (rem_c[i]),
            .den_i   (den_c[i]),
            .quot_i  (quot_c[i]),
            .ctl_i   (ctl_c[i]),
            .valid_o (valid_c[i+1]),
            .ready_i (ready_c[i+1]),
            .rem_o   (rem_c[i+1]),
            .den_o   (den_c[i+1]),
            .quot_o  (quot_c[i+1]),
            .ctl_o   (ctl_c[i+1])
        );
    end

    arf_fin #(
        .DIM_BITS (DIM_BITS)
    ) u_fin (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .valid_i      (valid_c[DIM_BITS]),
        .ready_o      (ready_c[DIM_BITS]),
        .quot_i       (quot_c[DIM_BITS]),
        .ctl_i        (ctl_c[DIM_BITS]),
        .dst_width_i  (dst_width_reg),
        .dst_height_i (dst_height_reg),
        .valid_o      (m_tvalid),
        .ready_i      (m_tready),
        .fit_x_o      (fit_x),
        .fit_y_o      (fit_y),
        .fit_width_o  (fit_width),
        .fit_height_o (fit_height)
    );

    assign m_tdata = OUT_W'({fit_height, fit_width, fit_y, fit_x});

    // With nothing waiting at the output, the whole chain must be able to advance.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled although the output register is empty");

endmodule
